FILE: hw/rtl/ptrd_pkg.sv
// Shared constants and types of the point-to-ray distance block.
package ptrd_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int DIST_BITS      = 25;
	localparam int SAT_SHIFT      = 34;
	localparam int FRAC_SHIFT     = 16;
	localparam int RAD_BITS       = SAT_SHIFT + FRAC_SHIFT;
	localparam int ROOT_BITS      = RAD_BITS / 2;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_PTR_BITS = 2;

	typedef enum logic [1:0] {
		REG_ORIGIN_X  = 2'd0,
		REG_ORIGIN_Y  = 2'd1,
		REG_THROUGH_X = 2'd2,
		REG_THROUGH_Y = 2'd3
	} reg_index_t;

endpackage

FILE: hw/rtl/ptrd_front.sv
// Front end: ray registers, products and classification of each query point.
module ptrd_front import ptrd_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [1:0]                   cfg_index,
	input  logic [COORD_BITS-1:0]        cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic                         q_full,
	output logic                         q_push,
	output logic [2*(2*COORD_BITS+2)+RAD_BITS+1:0] q_data
);

	localparam int DW   = COORD_BITS + 1;
	localparam int PW   = 2 * DW;
	localparam int SW   = 2 * COORD_BITS + 3;
	localparam int DDW  = 2 * COORD_BITS + 2;
	localparam int CW   = 2 * COORD_BITS + 2;
	localparam int H    = COORD_BITS + 1;
	localparam int C2W  = 4 * H;
	localparam int BIGW = (DDW > SAT_SHIFT) ? DDW : SAT_SHIFT + 1;
	localparam int CMPW = (C2W > DDW + SAT_SHIFT) ? C2W : DDW + SAT_SHIFT;

	logic signed [COORD_BITS-1:0] origin_x_q, origin_y_q, through_x_q, through_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			through_x_q <= COORD_BITS'(1);
			through_y_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (reg_index_t'(cfg_index))
				REG_ORIGIN_X:  origin_x_q  <= cfg_wdata;
				REG_ORIGIN_Y:  origin_y_q  <= cfg_wdata;
				REG_THROUGH_X: through_x_q <= cfg_wdata;
				REG_THROUGH_Y: through_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	assign en       = !v_s6 || !q_full;
	assign in_ready = en;
	assign q_push   = v_s6 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	logic signed [DW-1:0] ax_s1, ay_s1, dx_s1, dy_s1;
	logic signed [PW-1:0] dxdx_s2, dydy_s2, dxax_s2, dyay_s2, dxay_s2, dyax_s2;
	logic signed [PW-1:0] axax_s2, ayay_s2;
	logic [DDW-1:0]       dd_s3, sq_s3;
	logic signed [SW-1:0] dot_s3, cr_s3;
	logic                 org_s4, satq_s4;
	logic [CW-1:0]        c_s4;
	logic [DDW-1:0]       dd_s4;
	logic [RAD_BITS-1:0]  radq_s4;
	logic [2*H-1:0]       hh_s5, hl_s5, ll_s5;
	logic                 org_s5, satq_s5;
	logic [DDW-1:0]       dd_s5;
	logic [RAD_BITS-1:0]  radq_s5;
	logic [C2W-1:0]       c2_s6;
	logic                 org_s6, satq_s6;
	logic [DDW-1:0]       dd_s6;
	logic [RAD_BITS-1:0]  radq_s6;

	logic signed [SW-1:0] dd_sum, sq_sum, dot_sum, cr_sum, cr_neg;
	logic [CW-1:0]        c_abs;
	logic [BIGW-1:0]      sq_w;
	logic [C2W-1:0]       c2_sum, c2_sh;
	logic                 c2_sat;

	assign dd_sum  = SW'(dxdx_s2) + SW'(dydy_s2);
	assign sq_sum  = SW'(axax_s2) + SW'(ayay_s2);
	assign dot_sum = SW'(dxax_s2) + SW'(dyay_s2);
	assign cr_sum  = SW'(dxay_s2) - SW'(dyax_s2);
	assign cr_neg  = -cr_s3;
	assign c_abs   = cr_s3[SW-1] ? cr_neg[CW-1:0] : cr_s3[CW-1:0];
	assign sq_w    = BIGW'(sq_s3);
	assign c2_sum  = (C2W'(hh_s5) << (2 * H)) + (C2W'(hl_s5) << (H + 1)) + C2W'(ll_s5);
	assign c2_sat  = CMPW'(c2_s6) >= (CMPW'(dd_s6) << SAT_SHIFT);
	assign c2_sh   = c2_s6 >> SAT_SHIFT;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1   <= {point_x[COORD_BITS-1], point_x} - {origin_x_q[COORD_BITS-1], origin_x_q};
			ay_s1   <= {point_y[COORD_BITS-1], point_y} - {origin_y_q[COORD_BITS-1], origin_y_q};
			dx_s1   <= {through_x_q[COORD_BITS-1], through_x_q}
				- {origin_x_q[COORD_BITS-1], origin_x_q};
			dy_s1   <= {through_y_q[COORD_BITS-1], through_y_q}
				- {origin_y_q[COORD_BITS-1], origin_y_q};

			dxdx_s2 <= dx_s1 * dx_s1;
			dydy_s2 <= dy_s1 * dy_s1;
			dxax_s2 <= dx_s1 * ax_s1;
			dyay_s2 <= dy_s1 * ay_s1;
			dxay_s2 <= dx_s1 * ay_s1;
			dyax_s2 <= dy_s1 * ax_s1;
			axax_s2 <= ax_s1 * ax_s1;
			ayay_s2 <= ay_s1 * ay_s1;

			dd_s3   <= dd_sum[DDW-1:0];
			sq_s3   <= sq_sum[DDW-1:0];
			dot_s3  <= dot_sum;
			cr_s3   <= cr_sum;

			org_s4  <= (dd_s3 == '0) || dot_s3[SW-1] || (dot_s3 == '0);
			c_s4    <= c_abs;
			dd_s4   <= dd_s3;
			satq_s4 <= |sq_w[BIGW-1:SAT_SHIFT];
			radq_s4 <= {sq_w[SAT_SHIFT-1:0], {FRAC_SHIFT{1'b0}}};

			hh_s5   <= c_s4[CW-1:H] * c_s4[CW-1:H];
			hl_s5   <= c_s4[CW-1:H] * c_s4[H-1:0];
			ll_s5   <= c_s4[H-1:0] * c_s4[H-1:0];
			org_s5  <= org_s4;
			satq_s5 <= satq_s4;
			dd_s5   <= dd_s4;
			radq_s5 <= radq_s4;

			c2_s6   <= c2_sum;
			org_s6  <= org_s5;
			satq_s6 <= satq_s5;
			dd_s6   <= dd_s5;
			radq_s6 <= radq_s5;
		end
	end

	always_comb begin
		if (org_s6) begin
			q_data = {1'b1, satq_s6, {DDW{1'b0}}, dd_s6, radq_s6};
		end else begin
			q_data = {1'b0, c2_sat, c2_sh[DDW-1:0], dd_s6,
				c2_s6[SAT_SHIFT-1:0], {FRAC_SHIFT{1'b0}}};
		end
	end

endmodule

FILE: hw/rtl/ptrd_queue.sv
// Short request queue between the front end and the back end.
module ptrd_queue import ptrd_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] head
);

	logic [WIDTH-1:0]          mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wptr_q, rptr_q;
	logic [QUEUE_PTR_BITS:0]   cnt_q;

	assign full      = cnt_q == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH);
	assign not_empty = cnt_q != '0;
	assign head      = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/ptrd_back.sv
// Back end: pipelined restoring divider followed by a pipelined square root.
module ptrd_back import ptrd_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  logic [2*(2*COORD_BITS+2)+RAD_BITS+1:0] q_data,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DIST_BITS-1:0] distance,
	output logic                 nearest_is_origin
);

	localparam int DDW = 2 * COORD_BITS + 2;
	localparam int QB  = RAD_BITS;
	localparam int RB  = ROOT_BITS;
	localparam int EW  = 2 * DDW + QB + 2;

	logic en;

	logic           dv_v   [QB];
	logic           dv_org [QB];
	logic           dv_sat [QB];
	logic [DDW-1:0] dv_rem [QB];
	logic [DDW-1:0] dv_dd  [QB];
	logic [QB-1:0]  dv_qd  [QB];

	logic           sq_v    [RB];
	logic           sq_org  [RB];
	logic           sq_sat  [RB];
	logic [QB-1:0]  sq_rad  [RB];
	logic [RB-1:0]  sq_root [RB];
	logic [RB+1:0]  sq_rem  [RB];

	assign en    = !sq_v[RB-1] || out_ready;
	assign q_pop = en && q_valid;

	for (genvar i = 0; i < QB; i++) begin : g_div
		logic           v_in, org_in, sat_in, ge;
		logic [DDW-1:0] rem_in, dd_in;
		logic [QB-1:0]  qd_in;
		logic [DDW:0]   trial, diff;

		if (i == 0) begin : g_first
			assign v_in   = q_valid;
			assign org_in = q_data[EW-1];
			assign sat_in = q_data[EW-2];
			assign rem_in = q_data[QB+DDW +: DDW];
			assign dd_in  = q_data[QB +: DDW];
			assign qd_in  = q_data[QB-1:0];
		end else begin : g_next
			assign v_in   = dv_v[i-1];
			assign org_in = dv_org[i-1];
			assign sat_in = dv_sat[i-1];
			assign rem_in = dv_rem[i-1];
			assign dd_in  = dv_dd[i-1];
			assign qd_in  = dv_qd[i-1];
		end

		assign trial = {rem_in, qd_in[QB-1]};
		assign ge    = trial >= {1'b0, dd_in};
		assign diff  = trial - {1'b0, dd_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[i] <= 1'b0;
			end else if (en) begin
				dv_v[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_org[i] <= org_in;
				dv_sat[i] <= sat_in;
				dv_dd[i]  <= dd_in;
				if (org_in) begin
					dv_rem[i] <= rem_in;
					dv_qd[i]  <= qd_in;
				end else begin
					dv_rem[i] <= ge ? diff[DDW-1:0] : trial[DDW-1:0];
					dv_qd[i]  <= {qd_in[QB-2:0], ge};
				end
			end
		end
	end

	for (genvar j = 0; j < RB; j++) begin : g_sqrt
		logic          v_in, org_in, sat_in, ge;
		logic [QB-1:0] rad_in;
		logic [RB-1:0] root_in;
		logic [RB+1:0] rem_in, cur, trial;

		if (j == 0) begin : g_first
			assign v_in    = dv_v[QB-1];
			assign org_in  = dv_org[QB-1];
			assign sat_in  = dv_sat[QB-1];
			assign rad_in  = dv_qd[QB-1];
			assign root_in = '0;
			assign rem_in  = '0;
		end else begin : g_next
			assign v_in    = sq_v[j-1];
			assign org_in  = sq_org[j-1];
			assign sat_in  = sq_sat[j-1];
			assign rad_in  = sq_rad[j-1];
			assign root_in = sq_root[j-1];
			assign rem_in  = sq_rem[j-1];
		end

		assign cur   = {rem_in[RB-1:0], rad_in[QB-1:QB-2]};
		assign trial = {root_in, 2'b01};
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[j] <= 1'b0;
			end else if (en) begin
				sq_v[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_org[j]  <= org_in;
				sq_sat[j]  <= sat_in;
				sq_rad[j]  <= {rad_in[QB-3:0], 2'b00};
				sq_root[j] <= {root_in[RB-2:0], ge};
				sq_rem[j]  <= ge ? (cur - trial) : cur;
			end
		end
	end

	assign out_valid         = sq_v[RB-1];
	assign distance          = sq_sat[RB-1] ? {DIST_BITS{1'b1}} : DIST_BITS'(sq_root[RB-1]);
	assign nearest_is_origin = sq_org[RB-1];

endmodule

FILE: hw/rtl/point_to_ray_distance_top.sv
// Top level of the point-to-ray distance block.
//
//  Channel   Signals                                   Direction
//  config    cfg_wr_en, cfg_index, cfg_wdata           write only, no wait
//  point     in_valid/in_ready, point_x, point_y       request in
//  result    out_valid/out_ready, distance,            result out
//            nearest_is_origin
//
// One request is taken per cycle while in_ready is high; its result passes through
// 6 front stages, the queue, 50 divider stages and 25 square root stages, in that order.
// The divider and root retire one bit per stage.
// Reset clears all valid bits and the queue and loads the ray (0,0)-(1,0).
// A stalled result holds the back end; the queue lets the front keep going until it is full.
module point_to_ray_distance_top import ptrd_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [1:0]                   cfg_index,
	input  logic [COORD_BITS-1:0]        cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [DIST_BITS-1:0]         distance,
	output logic                         nearest_is_origin
);

	localparam int EW = 2 * (2 * COORD_BITS + 2) + RAD_BITS + 2;

	logic          q_full, q_push, q_pop, q_valid;
	logic [EW-1:0] q_in, q_head;

	ptrd_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.point_x   (point_x),
		.point_y   (point_y),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_in)
	);

	ptrd_queue #(.WIDTH(EW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	ptrd_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_valid           (q_valid),
		.q_data            (q_head),
		.q_pop             (q_pop),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.distance          (distance),
		.nearest_is_origin (nearest_is_origin)
	);

endmodule

FILE: dv/point_to_ray_distance_checker.sv
// Checker of the point-to-ray distance block: predicts each result and compares it.
module point_to_ray_distance_checker import ptrd_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  reg_index_t                  cfg_index,
	input  logic [COORD_BITS_DEF-1:0]   cfg_wdata,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic signed [COORD_BITS_DEF-1:0] point_x,
	input  logic signed [COORD_BITS_DEF-1:0] point_y,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [DIST_BITS-1:0]        distance,
	input  logic                        nearest_is_origin,
	output int                          errors,
	output int                          pending,
	output int                          n_near
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [DIST_BITS-1:0] DIST_SAT = '1;

	typedef struct packed {
		logic [DIST_BITS-1:0] dist_val;
		logic                 near;
	} ray_result_t;

	ray_result_t expected_q[$];
	logic signed [COORD_BITS_DEF-1:0] org_x, org_y, thr_x, thr_y;

	function automatic logic [63:0] int_sqrt(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic ray_result_t ray_distance(input logic signed [COORD_BITS_DEF-1:0] px,
			input logic signed [COORD_BITS_DEF-1:0] py);
		longint ax, ay, dx, dy, dd, dot, cr;
		logic [127:0] c2, sq, q, root;
		ray_result_t res;
		ax = longint'(px) - longint'(org_x);
		ay = longint'(py) - longint'(org_y);
		dx = longint'(thr_x) - longint'(org_x);
		dy = longint'(thr_y) - longint'(org_y);
		dd = dx * dx + dy * dy;
		dot = dx * ax + dy * ay;
		if (dd == 0 || dot <= 0) begin
			sq = 128'(ax * ax + ay * ay);
			if (sq >= (128'd1 << SAT_SHIFT))
				res.dist_val = DIST_SAT;
			else begin
				root = 128'(int_sqrt(64'(sq << FRAC_SHIFT)));
				res.dist_val = (root > 128'(DIST_SAT)) ? DIST_SAT : root[DIST_BITS-1:0];
			end
			res.near = 1'b1;
		end else begin
			cr = dx * ay - dy * ax;
			if (cr < 0)
				cr = -cr;
			c2 = 128'(cr) * 128'(cr);
			if (c2 >= (128'(dd) << SAT_SHIFT))
				res.dist_val = DIST_SAT;
			else begin
				q = (c2 << FRAC_SHIFT) / 128'(dd);
				root = 128'(int_sqrt(q[63:0]));
				res.dist_val = (root > 128'(DIST_SAT)) ? DIST_SAT : root[DIST_BITS-1:0];
			end
			res.near = 1'b0;
		end
		return res;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		ray_result_t exp_res;
		if (!arst_n) begin
			org_x <= '0;
			org_y <= '0;
			thr_x <= 16'sd1;
			thr_y <= '0;
			errors = 0;
			n_near = 0;
			expected_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("result with no request outstanding: distance %0d", distance);
					errors++;
				end else begin
					exp_res = expected_q.pop_front();
					if (distance !== exp_res.dist_val) begin
						$error("distance expected %0d actual %0d", exp_res.dist_val, distance);
						errors++;
					end
					if (nearest_is_origin !== exp_res.near) begin
						$error("nearest_is_origin expected %0d actual %0d",
							exp_res.near, nearest_is_origin);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				exp_res = ray_distance(point_x, point_y);
				if (exp_res.near)
					n_near++;
				expected_q.push_back(exp_res);
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_ORIGIN_X:  org_x <= cfg_wdata;
					REG_ORIGIN_Y:  org_y <= cfg_wdata;
					REG_THROUGH_X: thr_x <= cfg_wdata;
					REG_THROUGH_Y: thr_y <= cfg_wdata;
				endcase
			end
		end
	end
endmodule

FILE: dv/tb.sv
// Testbench top of the point-to-ray distance block: stimulus, ray settings and verdict.
module tb import ptrd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	reg_index_t cfg_index = REG_ORIGIN_X;
	logic [COORD_BITS_DEF-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [COORD_BITS_DEF-1:0] point_x = '0;
	logic signed [COORD_BITS_DEF-1:0] point_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [DIST_BITS-1:0] distance;
	logic nearest_is_origin;
	int errors, pending, n_near;
	int idle_mode = 0;
	int n_sent = 0;
	int n_settings = 0;
	logic [15:0] rnd_ox, rnd_oy;

	always #6 clk = ~clk;

	point_to_ray_distance_top u_top (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y), .out_valid(out_valid),
		.out_ready(out_ready), .distance(distance), .nearest_is_origin(nearest_is_origin)
	);

	point_to_ray_distance_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y), .out_valid(out_valid),
		.out_ready(out_ready), .distance(distance), .nearest_is_origin(nearest_is_origin),
		.errors(errors), .pending(pending), .n_near(n_near)
	);

	always @(posedge clk) begin
		case (idle_mode)
			0: out_ready <= ($urandom_range(99) >= 73);
			1: out_ready <= ($urandom_range(99) >= 36);
			default: out_ready <= 1'b1;
		endcase
	end

	task automatic send_point(input logic [15:0] x, input logic [15:0] y);
		int pct;
		point_x <= x;
		point_y <= y;
		in_valid <= 1'b1;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		n_sent++;
		pct = (idle_mode == 0) ? 36 : (idle_mode == 1) ? 73 : 0;
		while ($urandom_range(99) < pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_ray(input logic [15:0] ox, input logic [15:0] oy,
			input logic [15:0] tx, input logic [15:0] ty);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_ORIGIN_X;
		cfg_wdata <= ox;
		@(posedge clk);
		cfg_index <= REG_ORIGIN_Y;
		cfg_wdata <= oy;
		@(posedge clk);
		cfg_index <= REG_THROUGH_X;
		cfg_wdata <= tx;
		@(posedge clk);
		cfg_index <= REG_THROUGH_Y;
		cfg_wdata <= ty;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		n_settings++;
	endtask

	task automatic random_points(input int count, input logic [15:0] ox,
			input logic [15:0] oy);
		int kind;
		logic [15:0] x, y;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(99);
			x = 16'($urandom);
			y = 16'($urandom);
			if (kind < 15) begin
				x = ox + 16'($urandom_range(16)) - 16'd8;
				y = oy + 16'($urandom_range(16)) - 16'd8;
			end else if (kind < 30) begin
				x = $urandom_range(1) ? 16'h7fff : 16'h8000;
				y = $urandom_range(1) ? 16'h7fff : 16'h8000;
			end
			send_point(x, y);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset ray along +x: behind, on, ahead of the origin and the corners.
		send_point(16'd0, 16'd0);
		send_point(16'd1, 16'd0);
		send_point(16'hffff, 16'd0);
		send_point(16'd5, 16'd3);
		send_point(16'd5, 16'hfffd);
		send_point(16'd0, 16'd7);
		send_point(16'h7fff, 16'h7fff);
		send_point(16'h8000, 16'h8000);
		send_point(16'h7fff, 16'h8000);
		send_point(16'h8000, 16'h7fff);
		send_point(16'd3, 16'd4);
		random_points(200, 16'd0, 16'd0);

		set_ray(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
		send_point(16'h7fff, 16'h8000);
		send_point(16'h8000, 16'h7fff);
		send_point(16'h8000, 16'h8000);
		send_point(16'h7fff, 16'h7fff);
		random_points(200, 16'h8000, 16'h8000);

		idle_mode = 1;
		set_ray(16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
		send_point(16'h8000, 16'h8000);
		send_point(16'h7fff, 16'h8000);
		random_points(200, 16'h7fff, 16'h7fff);

		// Degenerate ray: origin and second point coincide.
		set_ray(16'd1234, 16'hfb2e, 16'd1234, 16'hfb2e);
		send_point(16'd1234, 16'hfb2e);
		send_point(16'h8000, 16'h7fff);
		send_point(16'd1237, 16'hfb32);
		random_points(200, 16'd1234, 16'hfb2e);

		idle_mode = 2;
		rnd_ox = 16'($urandom);
		rnd_oy = 16'($urandom);
		set_ray(rnd_ox, rnd_oy, 16'($urandom), 16'($urandom));
		random_points(200, rnd_ox, rnd_oy);

		set_ray(16'd0, 16'h7fff, 16'h8000, 16'h7fff);
		send_point(16'h8000, 16'h8000);
		random_points(200, 16'd0, 16'h7fff);

		drain();
		$display("Sent %0d points over %0d ray settings after reset, %0d nearest at origin.",
			n_sent, n_settings, n_near);
		$display("Settings covered corner-to-corner rays, a degenerate ray and random rays.");
		if (errors == 0 && pending == 0) begin
			$display("No mismatches found");
		end else begin
			if (pending != 0)
				$error("%0d expected results never arrived", pending);
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#30ms;
		$display("Mismatches found");
		$finish;
	end
endmodule
